// ===== rtl/sorted_neighbor_table_defines.svh =====
// Assertion macros for the sorted neighbour table
`ifndef SORTED_NEIGHBOR_TABLE_DEFINES_SVH
`define SORTED_NEIGHBOR_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define SNT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define SNT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SNT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define SNT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/snt_pkg.sv =====
// Shared constants, types and codes of the sorted neighbour table
`timescale 1ns / 1ps
`default_nettype none

package snt_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int COORD_W     = 10;
	localparam int DIST_W      = 16;
	localparam int RANK_W      = 5;
	localparam int STATUS_W    = 3;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED = 3'd0,
		ST_PRESENT  = 3'd1,
		ST_FULL     = 3'd2,
		ST_REMOVED  = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [DIST_W-1:0]  distance;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_INS_SHIFT,
		S_REM_SHIFT,
		S_PUBLISH
	} state_t;

	typedef enum logic [2:0] {
		CUR_HOLD,
		CUR_ZERO,
		CUR_INC,
		CUR_DEC,
		CUR_CNT
	} cur_op_t;

	typedef enum logic [2:0] {
		RD_ZERO,
		RD_CUR_P1,
		RD_CUR_P2,
		RD_CUR_M2,
		RD_CNT_M1
	} rd_sel_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC
	} cnt_op_t;

	typedef enum logic {
		RANK_ZERO,
		RANK_CUR
	} rank_sel_t;

	typedef struct packed {
		logic      in_ready;
		logic      load;
		cur_op_t   cur_op;
		logic      set_pos;
		rd_sel_t   rd_sel;
		logic      wr_en;
		logic      wr_new;
		cnt_op_t   cnt_op;
		logic      res_load;
		rank_sel_t rank_sel;
		status_t   res_status;
		logic      publish;
	} cmd_t;

	typedef struct packed {
		logic req_valid;
		logic op_rem;
		logic at_end;
		logic at_head;
		logic match;
		logic head_gt;
		logic dist_lt;
		logic full;
		logic at_pos;
		logic rem_last;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

// ===== rtl/snt_if.sv =====
// Request and response channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface snt_req_if;
	logic                        valid;
	logic                        ready;
	logic                        op;
	logic [snt_pkg::COORD_W-1:0] coord_x;
	logic [snt_pkg::COORD_W-1:0] coord_y;
	logic [snt_pkg::DIST_W-1:0]  distance;

	modport source (output valid, op, coord_x, coord_y, distance, input ready);
	modport sink (input valid, op, coord_x, coord_y, distance, output ready);
endinterface

interface snt_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [snt_pkg::RANK_W-1:0]   rank;
	logic [snt_pkg::STATUS_W-1:0] status;

	modport source (output valid, rank, status, input ready);
	modport sink (input valid, rank, status, output ready);
endinterface

`default_nettype wire

// ===== rtl/snt_datapath.sv =====
// Datapath: entry memory, cursor, count, compares and result register
`timescale 1ns / 1ps
`default_nettype none

module snt_datapath (
	input  wire logic      clk,
	input  wire logic      arst_n,
	snt_req_if.sink        req,
	snt_rsp_if.source      rsp,
	input  snt_pkg::cmd_t  cmd,
	output snt_pkg::stat_t stat
);

	snt_pkg::entry_t mem [snt_pkg::TABLE_DEPTH];
	snt_pkg::entry_t rd_data_q;
	snt_pkg::entry_t item_q;
	snt_pkg::entry_t wr_data;
	logic            op_q;

	logic [snt_pkg::CNT_W-1:0] cur_q;
	logic [snt_pkg::CNT_W-1:0] pos_q;
	logic [snt_pkg::CNT_W-1:0] cnt_q;
	logic [snt_pkg::CNT_W-1:0] rd_ptr;
	logic [snt_pkg::IDX_W-1:0] rd_idx;
	logic [snt_pkg::IDX_W-1:0] wr_idx;

	logic [snt_pkg::RANK_W-1:0] res_rank_q;
	snt_pkg::status_t           res_status_q;
	logic                       out_valid_q;
	logic [snt_pkg::RANK_W-1:0] out_rank_q;
	snt_pkg::status_t           out_status_q;

	always_comb begin
		unique case (cmd.rd_sel)
			snt_pkg::RD_ZERO:   rd_ptr = '0;
			snt_pkg::RD_CUR_P1: rd_ptr = cur_q + snt_pkg::CNT_W'(1);
			snt_pkg::RD_CUR_P2: rd_ptr = cur_q + snt_pkg::CNT_W'(2);
			snt_pkg::RD_CUR_M2: rd_ptr = cur_q - snt_pkg::CNT_W'(2);
			snt_pkg::RD_CNT_M1: rd_ptr = cnt_q - snt_pkg::CNT_W'(1);
			default:            rd_ptr = '0;
		endcase
	end

	// out-of-range addresses only occur on reads whose data is never used
	assign rd_idx  = rd_ptr[snt_pkg::IDX_W-1:0];
	assign wr_idx  = cur_q[snt_pkg::IDX_W-1:0];
	assign wr_data = cmd.wr_new ? item_q : rd_data_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		rd_data_q <= mem[rd_idx];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q            <= req.op;
			item_q.x        <= req.coord_x;
			item_q.y        <= req.coord_y;
			item_q.distance <= req.distance;
		end
		if (cmd.set_pos) begin
			pos_q <= cur_q;
		end
		if (cmd.res_load) begin
			res_status_q <= cmd.res_status;
			if (cmd.rank_sel == snt_pkg::RANK_CUR) begin
				res_rank_q <= snt_pkg::RANK_W'(cur_q + snt_pkg::CNT_W'(1));
			end else begin
				res_rank_q <= '0;
			end
		end
		if (cmd.publish) begin
			out_rank_q   <= res_rank_q;
			out_status_q <= res_status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (cmd.cur_op)
				snt_pkg::CUR_ZERO: cur_q <= '0;
				snt_pkg::CUR_INC:  cur_q <= cur_q + snt_pkg::CNT_W'(1);
				snt_pkg::CUR_DEC:  cur_q <= cur_q - snt_pkg::CNT_W'(1);
				snt_pkg::CUR_CNT:  cur_q <= cnt_q;
				default:           cur_q <= cur_q;
			endcase
			case (cmd.cnt_op)
				snt_pkg::CNT_INC: cnt_q <= cnt_q + snt_pkg::CNT_W'(1);
				snt_pkg::CNT_DEC: cnt_q <= cnt_q - snt_pkg::CNT_W'(1);
				default:          cnt_q <= cnt_q;
			endcase
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign req.ready  = cmd.in_ready;
	assign rsp.valid  = out_valid_q;
	assign rsp.rank   = out_rank_q;
	assign rsp.status = out_status_q;

	always_comb begin
		stat.req_valid = req.valid;
		stat.op_rem    = (op_q == snt_pkg::OP_REMOVE);
		stat.at_end    = (cur_q >= cnt_q);
		stat.at_head   = (cur_q == '0);
		stat.match     = (rd_data_q.x == item_q.x) && (rd_data_q.y == item_q.y);
		stat.head_gt   = (rd_data_q.distance > item_q.distance);
		stat.dist_lt   = (rd_data_q.distance < item_q.distance);
		stat.full      = (cnt_q == snt_pkg::CNT_W'(snt_pkg::TABLE_DEPTH));
		stat.at_pos    = (cur_q == pos_q);
		stat.rem_last  = ((cur_q + snt_pkg::CNT_W'(1)) == cnt_q);
		stat.out_free  = !out_valid_q || rsp.ready;
	end

endmodule

`default_nettype wire

// ===== rtl/snt_ctrl.sv =====
// Controller: scan, shift and publish sequencing
`timescale 1ns / 1ps
`default_nettype none

module snt_ctrl (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  snt_pkg::stat_t stat,
	output snt_pkg::cmd_t  cmd
);

	snt_pkg::state_t state_q;
	snt_pkg::state_t state_d;

	// insert scan reached its insertion point
	logic ins_place;
	// insert scan hit an entry with the same coordinates
	logic ins_present;

	always_comb begin
		ins_place   = 1'b0;
		ins_present = 1'b0;
		if (stat.at_end) begin
			ins_place = 1'b1;
		end else if (stat.at_head) begin
			ins_present = stat.match;
			ins_place   = !stat.match && stat.head_gt;
		end else if (!stat.dist_lt) begin
			ins_present = stat.match;
			ins_place   = !stat.match;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= snt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			snt_pkg::S_IDLE: begin
				if (stat.req_valid) state_d = snt_pkg::S_SCAN;
			end
			snt_pkg::S_SCAN: begin
				if (stat.op_rem) begin
					if (stat.at_end) state_d = snt_pkg::S_PUBLISH;
					else if (stat.match) state_d = snt_pkg::S_REM_SHIFT;
				end else if (ins_present) begin
					state_d = snt_pkg::S_PUBLISH;
				end else if (ins_place) begin
					state_d = stat.full ? snt_pkg::S_PUBLISH : snt_pkg::S_INS_SHIFT;
				end
			end
			snt_pkg::S_INS_SHIFT: begin
				if (stat.at_pos) state_d = snt_pkg::S_PUBLISH;
			end
			snt_pkg::S_REM_SHIFT: begin
				if (stat.rem_last) state_d = snt_pkg::S_PUBLISH;
			end
			snt_pkg::S_PUBLISH: begin
				if (stat.out_free) state_d = snt_pkg::S_IDLE;
			end
			default: state_d = snt_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.cur_op     = snt_pkg::CUR_HOLD;
		cmd.rd_sel     = snt_pkg::RD_ZERO;
		cmd.cnt_op     = snt_pkg::CNT_HOLD;
		cmd.rank_sel   = snt_pkg::RANK_ZERO;
		cmd.res_status = snt_pkg::ST_INSERTED;
		unique case (state_q)
			snt_pkg::S_IDLE: begin
				cmd.in_ready = 1'b1;
				cmd.load     = stat.req_valid;
				cmd.cur_op   = snt_pkg::CUR_ZERO;
				cmd.rd_sel   = snt_pkg::RD_ZERO;
			end
			snt_pkg::S_SCAN: begin
				cmd.rd_sel = snt_pkg::RD_CUR_P1;
				if (stat.op_rem) begin
					if (stat.at_end) begin
						cmd.res_load   = 1'b1;
						cmd.res_status = snt_pkg::ST_NOTFOUND;
					end else if (!stat.match) begin
						cmd.cur_op = snt_pkg::CUR_INC;
					end
				end else if (ins_present) begin
					cmd.res_load   = 1'b1;
					cmd.rank_sel   = snt_pkg::RANK_CUR;
					cmd.res_status = snt_pkg::ST_PRESENT;
				end else if (ins_place) begin
					if (stat.full) begin
						cmd.res_load   = 1'b1;
						cmd.res_status = snt_pkg::ST_FULL;
					end else begin
						cmd.set_pos = 1'b1;
						cmd.cur_op  = snt_pkg::CUR_CNT;
						cmd.rd_sel  = snt_pkg::RD_CNT_M1;
					end
				end else begin
					cmd.cur_op = snt_pkg::CUR_INC;
				end
			end
			snt_pkg::S_INS_SHIFT: begin
				cmd.wr_en = 1'b1;
				if (stat.at_pos) begin
					cmd.wr_new     = 1'b1;
					cmd.cnt_op     = snt_pkg::CNT_INC;
					cmd.res_load   = 1'b1;
					cmd.rank_sel   = snt_pkg::RANK_CUR;
					cmd.res_status = snt_pkg::ST_INSERTED;
				end else begin
					cmd.cur_op = snt_pkg::CUR_DEC;
					cmd.rd_sel = snt_pkg::RD_CUR_M2;
				end
			end
			snt_pkg::S_REM_SHIFT: begin
				if (stat.rem_last) begin
					cmd.cnt_op     = snt_pkg::CNT_DEC;
					cmd.res_load   = 1'b1;
					cmd.res_status = snt_pkg::ST_REMOVED;
				end else begin
					cmd.wr_en  = 1'b1;
					cmd.cur_op = snt_pkg::CUR_INC;
					cmd.rd_sel = snt_pkg::RD_CUR_P2;
				end
			end
			snt_pkg::S_PUBLISH: begin
				cmd.publish = stat.out_free;
			end
			default: begin
				cmd.in_ready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/sorted_neighbor_table.sv =====
// Sorted neighbour table top level
// Keeps up to TABLE_DEPTH neighbour entries in ascending distance order.
// req channel: op (insert/remove), coord_x, coord_y, distance (Q8.8).
// rsp channel: one transaction per request with rank and status.
// One request is worked on at a time; req.ready is high only while idle.
// A request walks the entry memory one entry per cycle (one read port,
// registered read data), then moves the entries behind the change one
// per cycle. The result sits in an output register, so the next request
// may be taken while that result waits; a further result is held until
// rsp.ready frees the register, and the block waits in the meantime.
// Reset clears the entry count and the output valid; the entry memory
// itself needs no clearing since only entries below the count are read.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_neighbor_table_defines.svh"

module sorted_neighbor_table (
	input wire logic  clk,
	input wire logic  arst_n,
	snt_req_if.sink   req,
	snt_rsp_if.source rsp
);

	snt_pkg::cmd_t  cmd;
	snt_pkg::stat_t stat;

	snt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	snt_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (cmd),
		.stat   (stat)
	);

	`SNT_ASSERT_NXT(a_one_at_a_time, clk, arst_n, req.valid && req.ready, !req.ready, "request taken while busy")
	`SNT_ASSERT_IMP(a_no_overfill, clk, arst_n, stat.full, cmd.cnt_op != snt_pkg::CNT_INC, "table overfilled")
	`SNT_ASSERT_IMP(a_publish_free, clk, arst_n, cmd.publish, !rsp.valid || rsp.ready, "result overwritten")
	`SNT_ASSERT_IMP(a_write_busy, clk, arst_n, cmd.wr_en, !cmd.in_ready, "memory write while idle")

endmodule

`default_nettype wire
